// ----- rtl/mbb_pkg.sv -----
// mbb_pkg: shared types and constants for the monochrome bitmap blitter
// command codes, register indexes, field widths and the stage control struct
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package mbb_pkg;

  localparam int CMD_W      = 2;
  localparam int PIX_W      = 8;
  localparam int ADDR_W     = 10;
  localparam int OX_W       = 7;
  localparam int OY_W       = 6;
  localparam int WB_W       = 5;
  localparam int H_W        = 7;
  localparam int ROW_CNT_W  = 6;
  localparam int ROW_LIMIT  = 64;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH_BYTES = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT      = 2'd3;

  typedef enum logic [CMD_W-1:0] {
    CMD_START = 2'd0,
    CMD_PIXEL = 2'd1,
    CMD_READ  = 2'd2
  } cmd_e;

  typedef struct packed {
    cmd_e kind;
    logic hit;   // pixel row on screen, or read address inside the frame
    logic done;  // last byte of the image
  } ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/mbb_row_mem.sv -----
// mbb_row_mem: frame store, one row of pixels per entry
// one write port, one read port with registered read data; no dependencies
`timescale 1ns / 1ps
`default_nettype none

module mbb_row_mem #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 96,
  localparam int AW   = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_idx,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_idx,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // read returns the old row when the same row is written in that cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_idx];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ----- rtl/mbb_front.sv -----
// mbb_front: input stage of the blitter; image column/row counters, clamping,
// row address for draw and read beats; uses mbb_pkg
`timescale 1ns / 1ps
`default_nettype none

module mbb_front #(
  parameter int SCREEN_ROWS     = 64,
  parameter int ROW_BYTES       = 12,
  parameter int MAX_IMAGE_WIDTH = 16,
  localparam int ROW_AW = $clog2(SCREEN_ROWS),
  localparam int COL_W  = (MAX_IMAGE_WIDTH > 1) ? $clog2(MAX_IMAGE_WIDTH) : 1
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [mbb_pkg::CMD_W-1:0]     in_cmd,
  input  wire logic [mbb_pkg::PIX_W-1:0]     in_pix,
  input  wire logic [mbb_pkg::ADDR_W-1:0]    in_addr,
  input  wire logic [mbb_pkg::OY_W-1:0]      origin_y,
  input  wire logic [mbb_pkg::WB_W-1:0]      width_bytes,
  input  wire logic [mbb_pkg::H_W-1:0]       image_height,
  input  wire logic                          clearing,
  input  wire logic                          s2_ready,
  output logic                               s1_valid,
  output mbb_pkg::ctrl_t                     s1_ctrl,
  output logic      [ROW_AW-1:0]             s1_row,
  output logic      [mbb_pkg::PIX_W-1:0]     s1_pix,
  output logic      [COL_W-1:0]              s1_col,
  output logic      [mbb_pkg::ADDR_W-1:0]    s1_addr
);

  localparam int WEF_W       = $clog2(MAX_IMAGE_WIDTH + 1);
  localparam int FRAME_BYTES = SCREEN_ROWS * ROW_BYTES;
  // floor(addr / ROW_BYTES) as a multiply by a rounded-up reciprocal
  localparam int SHIFT  = mbb_pkg::ADDR_W + $clog2(ROW_BYTES);
  localparam int RECIP  = (2 ** SHIFT + ROW_BYTES - 1) / ROW_BYTES;
  localparam int PROD_W = mbb_pkg::ADDR_W + SHIFT + 1;

  logic                              accept;
  logic [COL_W-1:0]                  col_r, col_nxt, col_cur;
  logic [mbb_pkg::ROW_CNT_W-1:0]     row_r, row_nxt, row_cur;
  logic [WEF_W-1:0]                  eff_w, col_inc;
  logic [mbb_pkg::H_W-1:0]           eff_h, row_inc, sy;
  logic                              last_col, last_row;
  logic [PROD_W-1:0]                 prod;
  logic [mbb_pkg::ADDR_W-1:0]        quo;
  mbb_pkg::cmd_e                     kind;
  logic                              hit, done;
  logic [ROW_AW-1:0]                 row_idx;

  logic                              s1_v_r;
  mbb_pkg::ctrl_t                    ctrl_r;
  logic [ROW_AW-1:0]                 row_idx_r;
  logic [mbb_pkg::PIX_W-1:0]         pix_r;
  logic [COL_W-1:0]                  col_s_r;
  logic [mbb_pkg::ADDR_W-1:0]        addr_r;

  assign in_tready = (!s1_v_r || s2_ready) && !clearing;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    if (width_bytes == '0) begin
      eff_w = WEF_W'(1);
    end else if (32'(width_bytes) > MAX_IMAGE_WIDTH) begin
      eff_w = WEF_W'(MAX_IMAGE_WIDTH);
    end else begin
      eff_w = WEF_W'(width_bytes);
    end
    if (image_height == '0) begin
      eff_h = mbb_pkg::H_W'(1);
    end else if (32'(image_height) > mbb_pkg::ROW_LIMIT) begin
      eff_h = mbb_pkg::H_W'(mbb_pkg::ROW_LIMIT);
    end else begin
      eff_h = image_height;
    end
  end

  // a counter left past a shrunken width or height starts over
  assign col_cur  = (32'(col_r) >= 32'(eff_w)) ? '0 : col_r;
  assign row_cur  = (32'(row_r) >= 32'(eff_h)) ? '0 : row_r;
  assign col_inc  = WEF_W'(col_cur) + WEF_W'(1);
  assign row_inc  = mbb_pkg::H_W'(row_cur) + mbb_pkg::H_W'(1);
  assign last_col = (col_inc >= eff_w);
  assign last_row = (row_inc >= eff_h);
  assign sy       = mbb_pkg::H_W'(origin_y) + mbb_pkg::H_W'(row_cur);

  assign prod = PROD_W'(in_addr) * PROD_W'(RECIP);
  assign quo  = mbb_pkg::ADDR_W'(prod >> SHIFT);

  always_comb begin
    kind    = mbb_pkg::cmd_e'(in_cmd);
    hit     = 1'b0;
    done    = 1'b0;
    col_nxt = col_r;
    row_nxt = row_r;
    row_idx = ROW_AW'(sy);
    unique case (kind)
      mbb_pkg::CMD_START: begin
        col_nxt = '0;
        row_nxt = '0;
      end
      mbb_pkg::CMD_PIXEL: begin
        hit = (32'(sy) < SCREEN_ROWS);
        if (last_col) begin
          col_nxt = '0;
          if (last_row) begin
            row_nxt = '0;
            done    = 1'b1;
          end else begin
            row_nxt = mbb_pkg::ROW_CNT_W'(row_inc);
          end
        end else begin
          col_nxt = COL_W'(col_inc);
          row_nxt = row_cur;
        end
      end
      mbb_pkg::CMD_READ: begin
        hit     = (32'(in_addr) < FRAME_BYTES);
        row_idx = ROW_AW'(quo);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      col_r  <= '0;
      row_r  <= '0;
    end else begin
      if (!s1_v_r || s2_ready) begin
        s1_v_r <= accept;
      end
      if (accept) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ctrl_r    <= '{kind: kind, hit: hit, done: done};
      row_idx_r <= row_idx;
      pix_r     <= in_pix;
      col_s_r   <= col_cur;
      addr_r    <= in_addr;
    end
  end

  assign s1_valid = s1_v_r;
  assign s1_ctrl  = ctrl_r;
  assign s1_row   = row_idx_r;
  assign s1_pix   = pix_r;
  assign s1_col   = col_s_r;
  assign s1_addr  = addr_r;

endmodule

`default_nettype wire

// ----- rtl/mbb_merge.sv -----
// mbb_merge: row read stage, byte merge into the row, write back and
// output register; uses mbb_pkg
`timescale 1ns / 1ps
`default_nettype none

module mbb_merge #(
  parameter int SCREEN_ROWS     = 64,
  parameter int ROW_BYTES       = 12,
  parameter int MAX_IMAGE_WIDTH = 16,
  localparam int ROW_AW   = $clog2(SCREEN_ROWS),
  localparam int COL_W    = (MAX_IMAGE_WIDTH > 1) ? $clog2(MAX_IMAGE_WIDTH) : 1,
  localparam int ROW_BITS = ROW_BYTES * 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          s1_valid,
  input  wire mbb_pkg::ctrl_t                s1_ctrl,
  input  wire logic [ROW_AW-1:0]             s1_row,
  input  wire logic [mbb_pkg::PIX_W-1:0]     s1_pix,
  input  wire logic [COL_W-1:0]              s1_col,
  input  wire logic [mbb_pkg::ADDR_W-1:0]    s1_addr,
  input  wire logic [mbb_pkg::OX_W-1:0]      origin_x,
  output logic                               s2_ready,
  output logic                               mem_rd_en,
  input  wire logic [ROW_BITS-1:0]           mem_rdata,
  output logic                               mem_we,
  output logic      [ROW_AW-1:0]             mem_widx,
  output logic      [ROW_BITS-1:0]           mem_wdata,
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic      [mbb_pkg::PIX_W-1:0]     out_data,
  output logic                               out_last
);

  localparam int RCOL_W = (ROW_BYTES > 1) ? $clog2(ROW_BYTES) : 1;
  localparam int BC_W   = $clog2(MAX_IMAGE_WIDTH + 16);

  logic                          out_rdy, s2_adv;
  logic                          s2_v_r, out_v_r;
  mbb_pkg::ctrl_t                s2_ctrl_r;
  logic [ROW_AW-1:0]             s2_row_r;
  logic [mbb_pkg::PIX_W-1:0]     s2_pix_r;
  logic [COL_W-1:0]              s2_col_r;
  logic [mbb_pkg::ADDR_W-1:0]    s2_addr_r;
  logic                          fwd_hit_r;
  logic [ROW_BITS-1:0]           fwd_data_r;
  logic [mbb_pkg::PIX_W-1:0]     out_data_r;
  logic                          out_last_r;

  logic [ROW_BITS-1:0]           row_data, new_row;
  logic [2:0]                    sh;
  logic                          aligned;
  logic [2*mbb_pkg::PIX_W-1:0]   spread;
  logic [BC_W-1:0]               bc0;
  logic [31:0]                   rbase;
  logic [RCOL_W-1:0]             rcol;
  logic [mbb_pkg::PIX_W-1:0]     rd_byte, out_data_nxt;

  assign out_rdy   = !out_v_r || out_tready;
  assign s2_ready  = !s2_v_r || out_rdy;
  assign s2_adv    = s2_v_r && out_rdy;
  assign mem_rd_en = s1_valid && s2_ready;
  assign mem_we    = s2_adv && (s2_ctrl_r.kind == mbb_pkg::CMD_PIXEL) && s2_ctrl_r.hit;
  assign mem_widx  = s2_row_r;
  assign mem_wdata = new_row;

  // a row written back in the same cycle as its read is taken from the bypass
  assign row_data = fwd_hit_r ? fwd_data_r : mem_rdata;

  always_comb begin
    sh      = origin_x[2:0];
    aligned = (sh == 3'd0);
    spread  = {s2_pix_r, {mbb_pkg::PIX_W{1'b0}}} >> sh;
    bc0     = BC_W'(origin_x[mbb_pkg::OX_W-1:3]) + BC_W'(s2_col_r);
    rbase   = 32'(s2_row_r) * 32'(ROW_BYTES);
    rcol    = RCOL_W'(32'(s2_addr_r) - rbase);
    rd_byte = '0;
    new_row = row_data;
    for (int b = 0; b < ROW_BYTES; b++) begin
      if (32'(bc0) == b) begin
        new_row[b*8 +: 8] = aligned ? s2_pix_r : (row_data[b*8 +: 8] | spread[15:8]);
      end else if (!aligned && (32'(bc0) + 32'd1 == b)) begin
        new_row[b*8 +: 8] = row_data[b*8 +: 8] | spread[7:0];
      end
      if (32'(rcol) == b) begin
        rd_byte = row_data[b*8 +: 8];
      end
    end
    out_data_nxt = ((s2_ctrl_r.kind == mbb_pkg::CMD_READ) && s2_ctrl_r.hit) ? rd_byte : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (s2_ready) begin
        s2_v_r <= s1_valid;
      end
      if (out_rdy) begin
        out_v_r <= s2_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_rd_en) begin
      s2_ctrl_r  <= s1_ctrl;
      s2_row_r   <= s1_row;
      s2_pix_r   <= s1_pix;
      s2_col_r   <= s1_col;
      s2_addr_r  <= s1_addr;
      fwd_hit_r  <= mem_we && (mem_widx == s1_row);
      fwd_data_r <= new_row;
    end
    if (s2_adv) begin
      out_data_r <= out_data_nxt;
      out_last_r <= s2_ctrl_r.done;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_data   = out_data_r;
  assign out_last   = out_last_r;

endmodule

`default_nettype wire

// ----- rtl/mono_bitmap_blitter.sv -----
// mono_bitmap_blitter: 1bpp image blit into a row-wide frame store
// pipeline: an accepted beat is registered in mbb_front, then in the merge stage, then in the output register
// throughput: one beat per cycle while the result side does not stall; an unaligned byte merges into one row entry
// reset: synchronous; then a clearing pass writes zero to each of the SCREEN_ROWS rows (64 by default), one row a
// cycle, with in_tready held low until the pass ends
`timescale 1ns / 1ps
`default_nettype none

module mono_bitmap_blitter #(
  parameter int SCREEN_ROWS     = 64,
  parameter int ROW_BYTES       = 12,
  parameter int MAX_IMAGE_WIDTH = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [23:0]                       in_tdata,   // image_byte[7:0], read_address[17:8]
  input  wire logic [mbb_pkg::CMD_W-1:0]         in_tuser,   // command[1:0]
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic      [7:0]                        out_tdata,  // read_data[7:0]
  output logic                                   out_tlast,  // image_done
  input  wire logic                              cfg_we,
  input  wire logic [mbb_pkg::CFG_IDX_W-1:0]     cfg_addr,
  input  wire logic [mbb_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  localparam int ROW_AW   = $clog2(SCREEN_ROWS);
  localparam int COL_W    = (MAX_IMAGE_WIDTH > 1) ? $clog2(MAX_IMAGE_WIDTH) : 1;
  localparam int ROW_BITS = ROW_BYTES * 8;

  logic [mbb_pkg::OX_W-1:0]     origin_x_r;
  logic [mbb_pkg::OY_W-1:0]     origin_y_r;
  logic [mbb_pkg::WB_W-1:0]     width_bytes_r;
  logic [mbb_pkg::H_W-1:0]      height_r;

  logic                         clr_active_r;
  logic [ROW_AW-1:0]            clr_idx_r;

  logic                         s2_ready, s1_valid;
  mbb_pkg::ctrl_t               s1_ctrl;
  logic [ROW_AW-1:0]            s1_row;
  logic [mbb_pkg::PIX_W-1:0]    s1_pix;
  logic [COL_W-1:0]             s1_col;
  logic [mbb_pkg::ADDR_W-1:0]   s1_addr;

  logic                         mem_rd_en, mg_we, mem_we;
  logic [ROW_AW-1:0]            mg_widx, mem_widx;
  logic [ROW_BITS-1:0]          mg_wdata, mem_wdata, mem_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r    <= '0;
      origin_y_r    <= '0;
      width_bytes_r <= mbb_pkg::WB_W'(1);
      height_r      <= mbb_pkg::H_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        mbb_pkg::REG_ORIGIN_X:    origin_x_r    <= mbb_pkg::OX_W'(cfg_wdata);
        mbb_pkg::REG_ORIGIN_Y:    origin_y_r    <= mbb_pkg::OY_W'(cfg_wdata);
        mbb_pkg::REG_WIDTH_BYTES: width_bytes_r <= mbb_pkg::WB_W'(cfg_wdata);
        mbb_pkg::REG_HEIGHT:      height_r      <= mbb_pkg::H_W'(cfg_wdata);
        default: begin
        end
      endcase
    end
  end

  // clearing pass over the frame store after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_idx_r    <= '0;
    end else if (clr_active_r) begin
      clr_idx_r <= clr_idx_r + ROW_AW'(1);
      if (clr_idx_r == ROW_AW'(SCREEN_ROWS - 1)) begin
        clr_active_r <= 1'b0;
      end
    end
  end

  assign mem_we    = clr_active_r || mg_we;
  assign mem_widx  = clr_active_r ? clr_idx_r : mg_widx;
  assign mem_wdata = clr_active_r ? '0 : mg_wdata;

  mbb_front #(
    .SCREEN_ROWS     (SCREEN_ROWS),
    .ROW_BYTES       (ROW_BYTES),
    .MAX_IMAGE_WIDTH (MAX_IMAGE_WIDTH)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_cmd       (in_tuser),
    .in_pix       (in_tdata[7:0]),
    .in_addr      (in_tdata[17:8]),
    .origin_y     (origin_y_r),
    .width_bytes  (width_bytes_r),
    .image_height (height_r),
    .clearing     (clr_active_r),
    .s2_ready     (s2_ready),
    .s1_valid     (s1_valid),
    .s1_ctrl      (s1_ctrl),
    .s1_row       (s1_row),
    .s1_pix       (s1_pix),
    .s1_col       (s1_col),
    .s1_addr      (s1_addr)
  );

  mbb_row_mem #(
    .DEPTH (SCREEN_ROWS),
    .WIDTH (ROW_BITS)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_idx  (mem_widx),
    .wr_data (mem_wdata),
    .rd_en   (mem_rd_en),
    .rd_idx  (s1_row),
    .rd_data (mem_rdata)
  );

  mbb_merge #(
    .SCREEN_ROWS     (SCREEN_ROWS),
    .ROW_BYTES       (ROW_BYTES),
    .MAX_IMAGE_WIDTH (MAX_IMAGE_WIDTH)
  ) u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .s1_valid   (s1_valid),
    .s1_ctrl    (s1_ctrl),
    .s1_row     (s1_row),
    .s1_pix     (s1_pix),
    .s1_col     (s1_col),
    .s1_addr    (s1_addr),
    .origin_x   (origin_x_r),
    .s2_ready   (s2_ready),
    .mem_rd_en  (mem_rd_en),
    .mem_rdata  (mem_rdata),
    .mem_we     (mg_we),
    .mem_widx   (mg_widx),
    .mem_wdata  (mg_wdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_data   (out_tdata),
    .out_last   (out_tlast)
  );

`ifndef SYNTHESIS
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_active_r |-> !in_tready)
    else $error("input beat taken during clearing pass");

  a_no_draw_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_active_r |-> !mg_we)
    else $error("draw write collides with clearing pass");

  a_done_has_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |-> (out_tdata == '0))
    else $error("image done beat carries read data");

  a_clear_starts_after_reset: assert property (@(posedge clk)
    $rose(rst_n) |-> clr_active_r)
    else $error("clearing pass not running after reset");
`endif

endmodule

`default_nettype wire

// ----- bench/tb_top.sv -----
// tb_top: self-checking bench for mono_bitmap_blitter; directed beats, then random image
// phases under random stalls on both sides, checked against an in-bench frame predictor
// depends on rtl/mbb_pkg.sv and rtl/mono_bitmap_blitter.sv
`timescale 1ns / 1ps

module tb_top;
  import mbb_pkg::*;

  localparam int SCREEN_ROWS = 64;
  localparam int ROW_BYTES   = 12;
  localparam int MAX_WIDTH   = 16;
  localparam int FRAME_BYTES = SCREEN_ROWS * ROW_BYTES;
  localparam int ROW_PIXELS  = ROW_BYTES * 8;
  localparam int TARGET_BEATS = 1150;
  localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;  // not decoded by the block

  typedef struct packed {
    logic [7:0] read_data;
    logic       image_done;
  } blit_result_t;

  class blit_scoreboard;
    logic [7:0]   frame_shadow [FRAME_BYTES];
    int unsigned  col_pos;
    int unsigned  row_pos;
    logic [OX_W-1:0] origin_x;
    logic [OY_W-1:0] origin_y;
    logic [WB_W-1:0] width_bytes;
    logic [H_W-1:0]  height_rows;
    blit_result_t expected_q [$];
    int errors;
    int checked;
    int images_done;

    function new();
      foreach (frame_shadow[i]) frame_shadow[i] = 8'h00;
      col_pos = 0;
      row_pos = 0;
      origin_x = '0;
      origin_y = '0;
      width_bytes = WB_W'(1);
      height_rows = H_W'(1);
      errors = 0;
      checked = 0;
      images_done = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_ORIGIN_X:    origin_x = val[OX_W-1:0];
        REG_ORIGIN_Y:    origin_y = val[OY_W-1:0];
        REG_WIDTH_BYTES: width_bytes = val[WB_W-1:0];
        REG_HEIGHT:      height_rows = val[H_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned eff_width();
      if (width_bytes == 0) return 1;
      if (width_bytes > MAX_WIDTH) return MAX_WIDTH;
      return width_bytes;
    endfunction

    function int unsigned eff_height();
      if (height_rows == 0) return 1;
      if (height_rows > ROW_LIMIT) return ROW_LIMIT;
      return height_rows;
    endfunction

    function void blit_byte(int unsigned col, int unsigned row, logic [7:0] pix);
      int unsigned sy;
      int unsigned base;
      int unsigned bc;
      int unsigned sx;
      sy = origin_y + row;
      if (sy >= SCREEN_ROWS) return;
      base = sy * ROW_BYTES;
      if (origin_x[2:0] == 3'd0) begin
        bc = col + (origin_x >> 3);
        if (bc < ROW_BYTES) frame_shadow[base + bc] = pix;
        return;
      end
      // unaligned: or each set pixel in, clipping at the right screen edge
      for (int b = 0; b < 8; b++) begin
        if (pix[7 - b]) begin
          sx = origin_x + col * 8 + b;
          if (sx < ROW_PIXELS)
            frame_shadow[base + (sx >> 3)] |= 8'h80 >> (sx & 7);
        end
      end
    endfunction

    function void note_beat(logic [CMD_W-1:0] cmd, logic [7:0] pix, logic [ADDR_W-1:0] addr);
      blit_result_t res;
      int unsigned w;
      int unsigned h;
      res = '0;
      w = eff_width();
      h = eff_height();
      case (cmd)
        CMD_START: begin
          col_pos = 0;
          row_pos = 0;
        end
        CMD_PIXEL: begin
          if (col_pos >= w) col_pos = 0;
          if (row_pos >= h) row_pos = 0;
          blit_byte(col_pos, row_pos, pix);
          col_pos++;
          if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
            if (row_pos >= h) begin
              row_pos = 0;
              res.image_done = 1'b1;
            end
          end
        end
        CMD_READ: begin
          if (addr < FRAME_BYTES) res.read_data = frame_shadow[addr];
        end
        default: ;
      endcase
      expected_q.push_back(res);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 30) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task check_beat(logic [7:0] data, logic last);
      blit_result_t exp_res;
      if (expected_q.size() == 0) begin
        report($sformatf("result beat data %02h last %b with nothing expected", data, last));
        return;
      end
      exp_res = expected_q.pop_front();
      checked++;
      if (data !== exp_res.read_data)
        report($sformatf("read_data %02h, expected %02h", data, exp_res.read_data));
      if (last !== exp_res.image_done)
        report($sformatf("image_done %b, expected %b", last, exp_res.image_done));
      if (exp_res.image_done) images_done++;
    endtask

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [23:0]           in_tdata = '0;   // image_byte[7:0], read_address[17:8]
  logic [CMD_W-1:0]      in_tuser = '0;   // command[1:0]
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [7:0]            out_tdata;       // read_data[7:0]
  logic                  out_tlast;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  blit_scoreboard sb;
  int  beats_sent = 0;
  int  setups = 0;
  bit  tx_gappy = 1'b1;
  bit  rx_gappy = 1'b1;
  bit  hold_request = 1'b0;
  int  hold_left = 0;
  int  stall_left = 0;

  always #1 clk = ~clk;

  mono_bitmap_blitter i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  // mostly no gap, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // beat monitor: predict on accepted input, check on accepted output
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_beat(in_tuser, in_tdata[7:0], in_tdata[17:8]);
      if (out_tvalid && out_tready) sb.check_beat(out_tdata, out_tlast);
    end
  end

  // result side back-pressure, with one long hold on request
  always @(posedge clk) begin
    if (hold_request) begin
      hold_request = 1'b0;
      hold_left = 300;
    end
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left--;
    end else if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left--;
    end else begin
      out_tready <= 1'b1;
      if (rx_gappy) stall_left = pick_gap();
    end
  end

  task automatic send_item(logic [CMD_W-1:0] cmd, logic [7:0] pix, logic [ADDR_W-1:0] addr);
    int gap;
    gap = tx_gappy ? pick_gap() : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= cmd;
    in_tdata <= {6'd0, addr, pix};
    do @(posedge clk); while (!in_tready);
    if (cmd != CMD_NONE) beats_sent++;
  endtask

  // called at the last accept edge: drop valid, then wait out every result
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    sb.set_reg(idx, val);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic setup(int ox, int oy, int wb, int ht);
    write_reg(REG_ORIGIN_X, CFG_DATA_W'(ox));
    write_reg(REG_ORIGIN_Y, CFG_DATA_W'(oy));
    write_reg(REG_WIDTH_BYTES, CFG_DATA_W'(wb));
    write_reg(REG_HEIGHT, CFG_DATA_W'(ht));
    setups++;
  endtask

  // read address somewhere near the current image origin
  function automatic logic [ADDR_W-1:0] near_addr();
    int row;
    int col;
    row = sb.origin_y + $urandom_range(0, 7);
    col = (sb.origin_x >> 3) + $urandom_range(0, 2);
    if (row > SCREEN_ROWS - 1) row = SCREEN_ROWS - 1;
    if (col > ROW_BYTES - 1) col = ROW_BYTES - 1;
    return ADDR_W'(row * ROW_BYTES + col);
  endfunction

  task automatic random_phase(int max_bytes);
    int ox;
    int oy;
    int wb;
    int ht;
    int nbytes;
    int r;
    r = $urandom_range(0, 9);
    if (r < 3) ox = 8 * $urandom_range(0, ROW_BYTES - 1);
    else if (r < 7) ox = $urandom_range(0, ROW_PIXELS - 1);
    else if (r < 8) ox = $urandom_range(ROW_PIXELS, 127);
    else begin
      r = $urandom_range(0, 2);
      ox = (r == 0) ? 0 : (r == 1) ? ROW_PIXELS - 1 : 127;
    end
    r = $urandom_range(0, 9);
    oy = (r < 7) ? $urandom_range(0, 63) : (r < 9) ? $urandom_range(56, 63) : 0;
    r = $urandom_range(0, 9);
    wb = (r < 7) ? $urandom_range(1, 4) : (r == 7) ? 0 : (r == 8) ? MAX_WIDTH :
         $urandom_range(MAX_WIDTH + 1, 31);
    r = $urandom_range(0, 9);
    ht = (r < 7) ? $urandom_range(1, 8) : (r == 7) ? 0 : (r == 8) ? ROW_LIMIT :
         $urandom_range(ROW_LIMIT + 1, 127);
    setup(ox, oy, wb, ht);

    nbytes = sb.eff_width() * sb.eff_height();
    if (nbytes > max_bytes) nbytes = $urandom_range(20, 60);
    else if ($urandom_range(0, 3) == 0) nbytes += $urandom_range(1, sb.eff_width());

    if ($urandom_range(0, 9) != 0) send_item(CMD_START, 8'($urandom), 10'($urandom));
    for (int k = 0; k < nbytes; k++) begin
      r = $urandom_range(0, 99);
      if (r < 78) send_item(CMD_PIXEL, 8'($urandom), 10'($urandom));
      else if (r < 90) send_item(CMD_READ, 8'($urandom), near_addr());
      else if (r < 94) send_item(CMD_READ, 8'($urandom), 10'($urandom));
      else if (r < 97) send_item(CMD_NONE, 8'($urandom), 10'($urandom));
      else send_item(CMD_START, 8'($urandom), 10'($urandom));
    end
    repeat (3) send_item(CMD_READ, 8'($urandom), near_addr());
  endtask

  initial begin
    sb = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: cleared frame, reads in and out of range, unused command,
    // a one-byte image that completes at once
    send_item(CMD_READ, 8'h00, 10'd0);
    send_item(CMD_READ, 8'hFF, 10'd767);
    send_item(CMD_READ, 8'hFF, 10'd1023);
    send_item(CMD_NONE, 8'hFF, 10'h3FF);
    send_item(CMD_PIXEL, 8'hFF, 10'd0);
    send_item(CMD_READ, 8'h00, 10'd0);
    drain();

    // aligned 2x2 image, then one byte past the end restarts it
    setup(0, 0, 2, 2);
    send_item(CMD_START, 8'h00, 10'd0);
    send_item(CMD_PIXEL, 8'h00, 10'd0);
    send_item(CMD_PIXEL, 8'hA5, 10'd0);
    send_item(CMD_PIXEL, 8'h5A, 10'd0);
    send_item(CMD_PIXEL, 8'hC3, 10'd0);
    send_item(CMD_PIXEL, 8'h81, 10'd0);
    send_item(CMD_READ, 8'h00, 10'd0);
    send_item(CMD_READ, 8'h00, 10'd13);
    drain();

    // unaligned at the bottom right corner, zero width and height act as one
    setup(93, 63, 0, 0);
    send_item(CMD_START, 8'h00, 10'd0);
    send_item(CMD_PIXEL, 8'hFF, 10'd0);
    send_item(CMD_READ, 8'h00, 10'd767);
    send_item(CMD_READ, 8'h00, 10'd766);
    drain();

    // origin past the screen, oversize width and height are clamped
    setup(127, 62, 31, 127);
    send_item(CMD_START, 8'h00, 10'd0);
    send_item(CMD_PIXEL, 8'hFF, 10'd0);
    send_item(CMD_PIXEL, 8'h80, 10'd0);
    send_item(CMD_READ, 8'h00, 10'd755);
    drain();

    while (beats_sent < TARGET_BEATS) begin
      if (setups == 8) begin
        // receiver holds off while the sender keeps offering
        tx_gappy = 1'b0;
        rx_gappy = 1'b0;
        setup(5, 10, 4, 4);
        hold_request = 1'b1;
        send_item(CMD_START, 8'h00, 10'd0);
        for (int k = 0; k < 16; k++) send_item(CMD_PIXEL, 8'($urandom), 10'($urandom));
        for (int k = 0; k < 12; k++) send_item(CMD_READ, 8'($urandom), near_addr());
      end else begin
        tx_gappy = ($urandom_range(0, 4) != 0);
        rx_gappy = ($urandom_range(0, 4) != 0);
        random_phase(80);
      end
      drain();
    end
    // one full image at the largest height, one byte wide
    setup(0, 0, 1, ROW_LIMIT);
    send_item(CMD_START, 8'h00, 10'd0);
    for (int k = 0; k < ROW_LIMIT; k++) send_item(CMD_PIXEL, 8'($urandom), 10'($urandom));
    drain();
    repeat (10) @(posedge clk);

    if (sb.pending() != 0) sb.report($sformatf("%0d results never arrived", sb.pending()));
    $display("run: %0d command beats in %0d settings, %0d results checked", beats_sent,
             setups, sb.checked);
    $display("run: %0d images completed, %0d mismatches", sb.images_done, sb.errors);
    if (sb.errors == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  initial begin
    #1500000;
    $display("timeout with %0d results outstanding", sb.pending());
    $display("tb_top NOT OK");
    $finish;
  end

endmodule
